@@ rtl/ssot_pkg.sv @@
package ssot_pkg;

    // item kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam int CFG_W   = 12;
    localparam int COUNT_W = 12;

    // one stored record
    typedef struct packed {
        logic [31:0] key;
        logic [2:0]  bar;
        logic [31:0] offset;
        logic [3:0]  size;
        logic        is_write;
        logic [31:0] value;
        logic        validated;
    } rec_t;

    // what a cell drives into the match tree; all zero when it does not match
    typedef struct packed {
        logic        hit;
        logic [2:0]  bar;
        logic [31:0] offset;
        logic [3:0]  size;
        logic        is_write;
        logic [31:0] value;
        logic        validated;
    } found_t;

    // broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic probe;
        logic insert;
        logic clear;
    } cell_cmd_t;

    // radix-8 registered OR tree depth
    function automatic int tree_levels(input int n);
        return ($clog2(n) + 2) / 3;
    endfunction

endpackage

@@ rtl/ssot_cell.sv @@
module ssot_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  ssot_pkg::cell_cmd_t cmd,
    input  ssot_pkg::rec_t    item,
    input  ssot_pkg::rec_t    prev_rec,
    input  logic              prev_occ,
    input  logic              prev_lt,
    output ssot_pkg::rec_t    rec,
    output logic              occ,
    output logic              lt,
    output ssot_pkg::found_t  found
);
    import ssot_pkg::*;

    rec_t rec_reg;
    logic occ_reg;
    logic lt_reg;
    logic match_reg;

    // control: occupancy and compare flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= 1'b0;
            lt_reg    <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                occ_reg <= 1'b0;
            end
            else if (cmd.insert && !lt_reg)
            begin
                occ_reg <= prev_lt ? 1'b1 : prev_occ;
            end
            if (cmd.probe)
            begin
                lt_reg    <= occ_reg && (rec_reg.key < item.key);
                match_reg <= occ_reg && (rec_reg.key == item.key);
            end
        end
    end

    // payload: keep if smaller key, else take new word or shift up from neighbor
    always_ff @(posedge clk)
    begin
        if (cmd.insert && !lt_reg)
        begin
            rec_reg <= prev_lt ? item : prev_rec;
        end
    end

    always_comb
    begin
        found = '0;
        if (match_reg)
        begin
            found.hit       = 1'b1;
            found.bar       = rec_reg.bar;
            found.offset    = rec_reg.offset;
            found.size      = rec_reg.size;
            found.is_write  = rec_reg.is_write;
            found.value     = rec_reg.value;
            found.validated = rec_reg.validated;
        end
    end

    assign rec = rec_reg;
    assign occ = occ_reg;
    assign lt  = lt_reg;

endmodule

@@ rtl/ssot_or_tree.sv @@
module ssot_or_tree #(
    parameter int N = 2048,
    parameter int W = 74
) (
    input  logic         clk,
    input  logic [W-1:0] leaf [N],
    output logic [W-1:0] root
);
    import ssot_pkg::*;

    localparam int LVL = tree_levels(N);
    localparam int PAD = 1 << (3 * LVL);

    logic [W-1:0] node [LVL+1][PAD];

    genvar j, k;
    generate
        for (j = 0; j < PAD; j++)
        begin : g_leaf
            if (j < N)
            begin : g_used
                assign node[0][j] = leaf[j];
            end
            else
            begin : g_pad
                assign node[0][j] = '0;
            end
        end

        for (k = 0; k < LVL; k++)
        begin : g_lvl
            for (j = 0; j < PAD; j++)
            begin : g_node
                if (j < (PAD >> (3 * (k + 1))))
                begin : g_reg
                    always_ff @(posedge clk)
                    begin
                        node[k+1][j] <= node[k][8*j]   | node[k][8*j+1] |
                                        node[k][8*j+2] | node[k][8*j+3] |
                                        node[k][8*j+4] | node[k][8*j+5] |
                                        node[k][8*j+6] | node[k][8*j+7];
                    end
                end
                else
                begin : g_unused
                    assign node[k+1][j] = '0;
                end
            end
        end
    endgenerate

    assign root = node[LVL][0];

endmodule

@@ rtl/seq_sorted_op_table_core.sv @@
// Sorted record table. Records live in a row of TABLE_DEPTH cells kept in
// ascending seq order from cell 0 up; each cell holds one record and an
// occupied flag. Every word (insert, lookup, clear) is taken one at a time:
// the seq is broadcast to all cells, which each compare it with their key,
// then the per-cell hits are merged by a registered radix-8 OR tree of
// L = ceil(log2(TABLE_DEPTH)/3) levels (4 for 2048 entries). An insert that
// is neither full nor a duplicate then shifts every cell above the slot up
// by one. The result sits in an output register, so a new word is
// accepted while the previous result waits for out_ready, but the block
// holds its answer back until that register is free. Status codes:
// 0 ok, 1 full (checked before duplicate), 2 duplicate seq, 3 not found.
// A capacity limit above TABLE_DEPTH acts as TABLE_DEPTH; zero makes every
// insert full. Write cfg_wr_en only while the block is idle.
module seq_sorted_op_table_core #(
    parameter int TABLE_DEPTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [31:0] seq,
    input  logic [2:0]  bar,
    input  logic [31:0] offset,
    input  logic [3:0]  access_size,
    input  logic        is_write,
    input  logic [31:0] data_value,
    input  logic        validated,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [2:0]  found_bar,
    output logic [31:0] found_offset,
    output logic [3:0]  found_size,
    output logic        found_is_write,
    output logic [31:0] found_value,
    output logic        found_validated,
    output logic [11:0] entry_count
);
    import ssot_pkg::*;

    localparam int LVL   = tree_levels(TABLE_DEPTH);
    localparam int WAIT_W = $clog2(LVL + 1);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int FW    = $bits(found_t);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CFG_W-1:0]  cap_reg;
    logic [1:0]        kind_reg;
    rec_t              item_reg;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    found_t            result_reg;
    logic [11:0]       entry_count_reg;

    cell_cmd_t         cmd;
    found_t            tree_found;
    logic [FW-1:0]     tree_root;

    rec_t              chain_rec [TABLE_DEPTH];
    logic              chain_occ [TABLE_DEPTH];
    logic              chain_lt  [TABLE_DEPTH];
    logic [FW-1:0]     leaf      [TABLE_DEPTH];

    logic              in_fire;
    logic              slot_free;
    logic              finish;
    logic              full;
    logic [CMP_W-1:0]  lim_eff;
    logic [1:0]        status_next;
    found_t            result_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign finish    = (state_reg == S_DONE) && slot_free;

    // ---------------- row of cells ----------------
    genvar i;
    generate
        for (i = 0; i < TABLE_DEPTH; i++)
        begin : g_cell
            found_t cell_found;
            if (i == 0)
            begin : g_head
                // nothing below the first cell: it takes the new record unless it holds a smaller key
                ssot_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .cmd      (cmd),
                    .item     (item_reg),
                    .prev_rec ('0),
                    .prev_occ (1'b0),
                    .prev_lt  (1'b1),
                    .rec      (chain_rec[i]),
                    .occ      (chain_occ[i]),
                    .lt       (chain_lt[i]),
                    .found    (cell_found)
                );
            end
            else
            begin : g_body
                ssot_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .cmd      (cmd),
                    .item     (item_reg),
                    .prev_rec (chain_rec[i-1]),
                    .prev_occ (chain_occ[i-1]),
                    .prev_lt  (chain_lt[i-1]),
                    .rec      (chain_rec[i]),
                    .occ      (chain_occ[i]),
                    .lt       (chain_lt[i]),
                    .found    (cell_found)
                );
            end
            assign leaf[i] = cell_found;
        end
    endgenerate

    // keys are unique, so at most one cell drives a nonzero word
    ssot_or_tree #(
        .N (TABLE_DEPTH),
        .W (FW)
    ) u_tree (
        .clk  (clk),
        .leaf (leaf),
        .root (tree_root)
    );

    assign tree_found = tree_root;

    // ---------------- decision ----------------
    always_comb
    begin
        lim_eff = (CMP_W'(cap_reg) > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH)
                                                          : CMP_W'(cap_reg);
        full        = (CMP_W'(count_reg) >= lim_eff);
        status_next = ST_OK;
        result_next = '0;
        count_next  = count_reg;
        cmd         = '0;
        cmd.probe   = (state_reg == S_PROBE);

        unique case (kind_reg)
            KIND_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else if (tree_found.hit)
                begin
                    status_next = ST_DUPLICATE;
                end
                else
                begin
                    cmd.insert = finish;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_LOOKUP:
            begin
                if (tree_found.hit)
                begin
                    result_next = tree_found;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            KIND_CLEAR:
            begin
                cmd.clear  = finish;
                count_next = '0;
            end
            default:
            begin
                // unused kind: no change, plain ok
            end
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                state_next = S_WAIT;
                wait_next  = WAIT_W'(LVL);
            end
            S_WAIT:
            begin
                wait_next = wait_reg - WAIT_W'(1);
                if (wait_reg == WAIT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CFG_W'(2048);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (finish)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg           <= kind;
            item_reg.key       <= seq;
            item_reg.bar       <= bar;
            item_reg.offset    <= offset;
            item_reg.size      <= access_size;
            item_reg.is_write  <= is_write;
            item_reg.value     <= data_value;
            item_reg.validated <= validated;
        end
        if (finish)
        begin
            status_reg      <= status_next;
            result_reg      <= result_next;
            entry_count_reg <= COUNT_W'(count_next);
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign found_bar       = result_reg.bar;
    assign found_offset    = result_reg.offset;
    assign found_size      = result_reg.size;
    assign found_is_write  = result_reg.is_write;
    assign found_value     = result_reg.value;
    assign found_validated = result_reg.validated;
    assign entry_count     = entry_count_reg;

endmodule

@@ rtl/ssot_checker.sv @@
module ssot_checker #(
    parameter int TABLE_DEPTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [31:0] seq,
    input  logic [2:0]  bar,
    input  logic [31:0] offset,
    input  logic [3:0]  access_size,
    input  logic        is_write,
    input  logic [31:0] data_value,
    input  logic        validated,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [2:0]  found_bar,
    input  logic [31:0] found_offset,
    input  logic [3:0]  found_size,
    input  logic        found_is_write,
    input  logic [31:0] found_value,
    input  logic        found_validated,
    input  logic [11:0] entry_count
);
    import ssot_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(entry_count) && $stable(found_value))
        else $error("result changed while stalled");

    // one word in flight: no back-to-back acceptance
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word accepted while busy");

    // record fields are only returned on a successful lookup
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> found_bar == 3'd0 &&
        found_offset == 32'd0 && found_size == 4'd0 && !found_is_write &&
        found_value == 32'd0 && !found_validated)
        else $error("record fields set on a failed word");

    // count never exceeds the table depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && TABLE_DEPTH < 4096 |-> 32'(entry_count) <= 32'(TABLE_DEPTH))
        else $error("entry count above table depth");

endmodule

bind seq_sorted_op_table_core ssot_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_ssot_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

// Sorted record table: directed and random words through the valid/ready
// channels, with an in-bench model of the table predicting every answer.
module testbench;

    import ssot_pkg::*;

    // kind 3 has no package name; the block answers it like a no-op
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int TABLE_DEPTH  = 2048;
    // drain margin after the last answer; give it plenty
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_PRINTS   = 50;
    // ~1100 words in total is well under this
    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // one input word, as driven on the payload ports
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] seq;
        logic [2:0]  bar;
        logic [31:0] offset;
        logic [3:0]  size;
        logic        is_write;
        logic [31:0] value;
        logic        validated;
    } access_word_t;

    // one answer word, as seen on the output ports
    typedef struct {
        logic [1:0]  status;
        logic [2:0]  bar;
        logic [31:0] offset;
        logic [3:0]  size;
        logic        is_write;
        logic [31:0] value;
        logic        validated;
        logic [11:0] count;
    } answer_t;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [11:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [1:0]  kind        = '0;
    logic [31:0] seq         = '0;
    logic [2:0]  bar         = '0;
    logic [31:0] offset      = '0;
    logic [3:0]  access_size = '0;
    logic        is_write    = 1'b0;
    logic [31:0] data_value  = '0;
    logic        validated   = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [1:0]  status;
    logic [2:0]  found_bar;
    logic [31:0] found_offset;
    logic [3:0]  found_size;
    logic        found_is_write;
    logic [31:0] found_value;
    logic        found_validated;
    logic [11:0] entry_count;

    seq_sorted_op_table_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .seq             (seq),
        .bar             (bar),
        .offset          (offset),
        .access_size     (access_size),
        .is_write        (is_write),
        .data_value      (data_value),
        .validated       (validated),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .found_bar       (found_bar),
        .found_offset    (found_offset),
        .found_size      (found_size),
        .found_is_write  (found_is_write),
        .found_value     (found_value),
        .found_validated (found_validated),
        .entry_count     (entry_count)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    access_word_t pending_words[$];     // words not yet on the bus
    answer_t      expected_answers[$];  // predicted answers, oldest first
    access_word_t word_on_bus;          // copy of what the payload ports carry
    access_word_t next_word;
    answer_t      oldest_answer;

    // table model: records in ascending seq order, plus the limit register
    rec_t         held_recs[$];
    logic [11:0]  model_limit = 12'd2048;

    int           send_idle_pct = 0;
    int           stall_pct     = 0;
    int           error_count   = 0;

    // ------------------------------------------------------------------
    // Table model. Called once per accepted word, in acceptance order.
    // ------------------------------------------------------------------
    function automatic answer_t apply_word(input access_word_t w);
        answer_t a;
        int      limit;
        int      pos;
        bit      hit;
        rec_t    r;

        a = '{default: '0};
        a.status = ST_OK;
        // limits above the depth act as the depth; zero refuses every insert
        limit = (model_limit > TABLE_DEPTH) ? TABLE_DEPTH : int'(model_limit);

        // first slot whose key is not below the seq
        pos = 0;
        while (pos < held_recs.size() && held_recs[pos].key < w.seq)
            pos++;
        hit = (pos < held_recs.size()) && (held_recs[pos].key == w.seq);

        case (w.kind)
            KIND_INSERT:
            begin
                // full wins over duplicate; count above a lowered limit is kept
                if (held_recs.size() >= limit)
                    a.status = ST_FULL;
                else if (hit)
                    a.status = ST_DUPLICATE;
                else
                begin
                    // record fields go in unchecked
                    r.key       = w.seq;
                    r.bar       = w.bar;
                    r.offset    = w.offset;
                    r.size      = w.size;
                    r.is_write  = w.is_write;
                    r.value     = w.value;
                    r.validated = w.validated;
                    held_recs.insert(pos, r);
                end
            end
            KIND_LOOKUP:
            begin
                if (hit)
                begin
                    a.bar       = held_recs[pos].bar;
                    a.offset    = held_recs[pos].offset;
                    a.size      = held_recs[pos].size;
                    a.is_write  = held_recs[pos].is_write;
                    a.value     = held_recs[pos].value;
                    a.validated = held_recs[pos].validated;
                end
                else
                    a.status = ST_NOT_FOUND;
            end
            KIND_CLEAR:
                held_recs.delete();
            default:
                ; // unused kind: nothing changes, status ok
        endcase

        a.count = 12'(held_recs.size());
        return a;
    endfunction

    function automatic access_word_t make_access(
        input logic [1:0]  k,
        input logic [31:0] s,
        input logic [2:0]  b,
        input logic [31:0] off,
        input logic [3:0]  sz,
        input logic        wr,
        input logic [31:0] val,
        input logic        vld
    );
        access_word_t w;

        w.kind      = k;
        w.seq       = s;
        w.bar       = b;
        w.offset    = off;
        w.size      = sz;
        w.is_write  = wr;
        w.value     = val;
        w.validated = vld;
        return w;
    endfunction

    // Random word. Keys cluster near both ends of the seq range so that
    // duplicates and lookup hits are common; a few are fully random.
    function automatic access_word_t random_word(input int key_span);
        access_word_t w;
        int           pick;
        int           sel;

        pick = $urandom_range(99);
        sel  = $urandom_range(9);
        if (pick < 48)
            w.kind = KIND_INSERT;
        else if (pick < 92)
            w.kind = KIND_LOOKUP;
        else if (pick < 94)
            w.kind = KIND_CLEAR;
        else
            w.kind = KIND_UNUSED;

        if (sel < 5)
            w.seq = $urandom_range(key_span - 1);
        else if (sel < 9)
            w.seq = 32'hFFFF_FFFF - $urandom_range(key_span - 1);
        else
            w.seq = $urandom();

        w.bar    = 3'($urandom_range(7));
        w.offset = $urandom();
        // mostly legal widths, sometimes anything the field holds
        if ($urandom_range(9) < 8)
            w.size = 4'd1 << $urandom_range(3);
        else
            w.size = 4'($urandom_range(15));
        w.is_write  = 1'($urandom_range(1));
        w.value     = $urandom();
        w.validated = 1'($urandom_range(1));
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: presents queued words, predicts each one as it is accepted.
    // Only touches the bus when it is empty or the word on it just went in,
    // so valid and payload hold steady under backpressure.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_answers.push_back(apply_word(word_on_bus));

            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_word    = pending_words.pop_front();
                    word_on_bus <= next_word;
                    in_valid    <= 1'b1;
                    kind        <= next_word.kind;
                    seq         <= next_word.seq;
                    bar         <= next_word.bar;
                    offset      <= next_word.offset;
                    access_size <= next_word.size;
                    is_write    <= next_word.is_write;
                    data_value  <= next_word.value;
                    validated   <= next_word.validated;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random backpressure, field-by-field check of each answer
    // against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
            if (out_valid && out_ready)
            begin
                if (expected_answers.size() == 0)
                    report_mismatch("unexpected word, entry_count", 32'(entry_count), 32'd0);
                else
                begin
                    oldest_answer = expected_answers.pop_front();
                    if (status !== oldest_answer.status)
                        report_mismatch("status", 32'(status), 32'(oldest_answer.status));
                    if (found_bar !== oldest_answer.bar)
                        report_mismatch("found_bar", 32'(found_bar),
                                        32'(oldest_answer.bar));
                    if (found_offset !== oldest_answer.offset)
                        report_mismatch("found_offset", found_offset, oldest_answer.offset);
                    if (found_size !== oldest_answer.size)
                        report_mismatch("found_size", 32'(found_size),
                                        32'(oldest_answer.size));
                    if (found_is_write !== oldest_answer.is_write)
                        report_mismatch("found_is_write", 32'(found_is_write),
                                        32'(oldest_answer.is_write));
                    if (found_value !== oldest_answer.value)
                        report_mismatch("found_value", found_value, oldest_answer.value);
                    if (found_validated !== oldest_answer.validated)
                        report_mismatch("found_validated", 32'(found_validated),
                                        32'(oldest_answer.validated));
                    if (entry_count !== oldest_answer.count)
                        report_mismatch("entry_count", 32'(entry_count),
                                        32'(oldest_answer.count));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencing helpers. Queue and knob updates happen at the falling
    // edge so they never race the clocked blocks above.
    // ------------------------------------------------------------------
    task automatic set_idling(input idle_mode_t mode);
        send_idle_pct = (mode == IDLE_SENDER || mode == IDLE_RECEIVER) ?
                        ((mode == IDLE_SENDER) ? 80 : 0) : ((mode == IDLE_BOTH) ? 11 : 0);
        stall_pct     = (mode == IDLE_RECEIVER) ? 80 : ((mode == IDLE_BOTH) ? 11 : 0);
    endtask

    // only called with the block idle
    task automatic set_limit(input logic [11:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        model_limit = v;
        @(negedge clk);
    endtask

    // wait for every queued word to go in and every answer to come back
    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_answers.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_phase(input idle_mode_t mode, input logic [11:0] limit,
                                input int count, input int key_span);
        set_idling(mode);
        set_limit(limit);
        repeat (count) pending_words.push_back(random_word(key_span));
        drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, reset limit: extremes of every field, sorted placement
        set_idling(IDLE_NONE);
        pending_words.push_back(make_access(KIND_LOOKUP, 32'd5, 3'd0, 32'd0, 4'd0,
                                            1'b0, 32'd0, 1'b0));
        pending_words.push_back(make_access(KIND_INSERT, 32'd0, 3'd0, 32'd0, 4'd1,
                                            1'b0, 32'd0, 1'b0));
        pending_words.push_back(make_access(KIND_INSERT, 32'hFFFF_FFFF, 3'd7,
                                            32'hFFFF_FFFF, 4'd15, 1'b1,
                                            32'hFFFF_FFFF, 1'b1));
        pending_words.push_back(make_access(KIND_INSERT, 32'h8000_0000, 3'd6,
                                            32'h0000_1000, 4'd8, 1'b1,
                                            32'h1234_5678, 1'b0));
        // duplicate seq
        pending_words.push_back(make_access(KIND_INSERT, 32'd0, 3'd5, 32'd9, 4'd2,
                                            1'b1, 32'd9, 1'b1));
        // lands between held keys
        pending_words.push_back(make_access(KIND_INSERT, 32'd1, 3'd2, 32'h40, 4'd2,
                                            1'b0, 32'hA5A5_A5A5, 1'b1));
        pending_words.push_back(make_access(KIND_INSERT, 32'h7FFF_FFFF, 3'd3,
                                            32'h8000_0000, 4'd4, 1'b1,
                                            32'h5A5A_5A5A, 1'b0));
        pending_words.push_back(make_access(KIND_LOOKUP, 32'd0, 3'd0, 32'd0, 4'd0,
                                            1'b0, 32'd0, 1'b0));
        pending_words.push_back(make_access(KIND_LOOKUP, 32'hFFFF_FFFF, 3'd0, 32'd0,
                                            4'd0, 1'b0, 32'd0, 1'b0));
        pending_words.push_back(make_access(KIND_LOOKUP, 32'h8000_0000, 3'd0, 32'd0,
                                            4'd0, 1'b0, 32'd0, 1'b0));
        pending_words.push_back(make_access(KIND_LOOKUP, 32'd1, 3'd0, 32'd0, 4'd0,
                                            1'b0, 32'd0, 1'b0));
        pending_words.push_back(make_access(KIND_LOOKUP, 32'h7FFF_FFFF, 3'd0, 32'd0,
                                            4'd0, 1'b0, 32'd0, 1'b0));
        pending_words.push_back(make_access(KIND_LOOKUP, 32'd2, 3'd0, 32'd0, 4'd0,
                                            1'b0, 32'd0, 1'b0));
        // unused kind with every other field high
        pending_words.push_back(make_access(KIND_UNUSED, 32'hFFFF_FFFF, 3'd7,
                                            32'hFFFF_FFFF, 4'd15, 1'b1,
                                            32'hFFFF_FFFF, 1'b1));
        pending_words.push_back(make_access(KIND_CLEAR, 32'd0, 3'd0, 32'd0, 4'd0,
                                            1'b0, 32'd0, 1'b0));
        pending_words.push_back(make_access(KIND_LOOKUP, 32'd0, 3'd0, 32'd0, 4'd0,
                                            1'b0, 32'd0, 1'b0));
        pending_words.push_back(make_access(KIND_INSERT, 32'd42, 3'd1, 32'd4, 4'd4,
                                            1'b1, 32'd42, 1'b1));
        drain();

        // limit 2 with one held: fill, then full before duplicate
        set_limit(12'd2);
        pending_words.push_back(make_access(KIND_INSERT, 32'd10, 3'd4, 32'd8, 4'd1,
                                            1'b0, 32'd10, 1'b0));
        pending_words.push_back(make_access(KIND_INSERT, 32'd11, 3'd4, 32'd8, 4'd1,
                                            1'b0, 32'd11, 1'b0));
        pending_words.push_back(make_access(KIND_INSERT, 32'd42, 3'd4, 32'd8, 4'd1,
                                            1'b0, 32'd42, 1'b0));
        pending_words.push_back(make_access(KIND_LOOKUP, 32'd10, 3'd0, 32'd0, 4'd0,
                                            1'b0, 32'd0, 1'b0));
        drain();

        // limit lowered below the count: full until a clear
        set_limit(12'd1);
        pending_words.push_back(make_access(KIND_INSERT, 32'd5, 3'd2, 32'd1, 4'd2,
                                            1'b1, 32'd5, 1'b1));
        pending_words.push_back(make_access(KIND_CLEAR, 32'd0, 3'd0, 32'd0, 4'd0,
                                            1'b0, 32'd0, 1'b0));
        pending_words.push_back(make_access(KIND_INSERT, 32'd5, 3'd2, 32'd1, 4'd2,
                                            1'b1, 32'd5, 1'b1));
        pending_words.push_back(make_access(KIND_INSERT, 32'd6, 3'd2, 32'd1, 4'd2,
                                            1'b1, 32'd6, 1'b1));
        drain();

        // limit zero refuses every insert, held records stay readable
        set_limit(12'd0);
        pending_words.push_back(make_access(KIND_INSERT, 32'd7, 3'd0, 32'd0, 4'd1,
                                            1'b0, 32'd7, 1'b0));
        pending_words.push_back(make_access(KIND_LOOKUP, 32'd5, 3'd0, 32'd0, 4'd0,
                                            1'b0, 32'd0, 1'b0));
        drain();

        // random part; limit above depth, one, zero, mid values, reset value
        random_phase(IDLE_NONE,     12'd4095, 150, 64);
        random_phase(IDLE_SENDER,   12'd1,     80,  8);
        random_phase(IDLE_RECEIVER, 12'd2048, 150, 64);
        random_phase(IDLE_BOTH,     12'd0,     60, 16);
        random_phase(IDLE_BOTH,     12'd8,    150, 16);
        random_phase(IDLE_NONE,     12'($urandom_range(40, 2)), 150, 32);
        random_phase(IDLE_SENDER,   12'd3,    120, 16);
        random_phase(IDLE_RECEIVER, 12'd700,  150, 1024);
        random_phase(IDLE_NONE,     12'd2048, 100, 64);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
